/* design/vna_pkg.sv */
// vna_pkg: shared types and codes for the vertex normal accumulator
// no dependencies; used by every module of the block but vna_fifo
`default_nettype none

package vna_pkg;

  localparam int IDX_W = 10;
  localparam int CFG_W = 11;
  localparam int POS_W = 16;
  localparam int NRM_W = 16;
  localparam int OUT_W = 24;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TRI   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic [IDX_W-1:0]        index_a;
    logic [IDX_W-1:0]        index_b;
    logic [IDX_W-1:0]        index_c;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
  } result_t;

  typedef struct packed {
    item_t item;
    logic  range_err;
  } cmd_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic                    done;
    logic                    degen;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
  } nrm_res_t;

endpackage

`default_nettype wire

/* design/vertex_normal_accumulator.sv */
// vertex_normal_accumulator: top level, front classifier, command queue, back sequencer
// depends on vna_pkg, vna_front, vna_fifo, vna_back (and vna_norm below it)
`default_nettype none

// Smooth vertex normals by face normal accumulation. Load positions (q4.12) with
// op load, send triangles to add their unit normal (q1.14) to the three corner
// accumulators, read an accumulator back with op read, and wipe them with op
// clear. Each item gives exactly one result beat. Items are taken one at a time
// by the back sequencer: a triangle waits on the 32-step square root loop and
// three 15-step divisions of the normal unit, and a clear writes one accumulator
// entry per cycle. After reset the same clearing sweep runs, during which items
// queue up but are not carried out. Two-entry queues sit in front of and behind
// the sequencer, so push and pop never wait on each other directly.
// vertex_count may only be written while idle.
module vertex_normal_accumulator #(
  parameter int MAX_VERTICES = 1024,
  parameter int ACCUM_BITS   = 24
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // input queue side
  input  wire logic                      push,
  output logic                           full,
  input  wire vna_pkg::item_t            item,
  // result queue side
  output logic                           empty,
  input  wire logic                      pop,
  output vna_pkg::result_t               result,
  // vertex count register write channel
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [vna_pkg::CFG_W-1:0] cfg_data
);

  vna_pkg::cmd_t    cmd_in;
  vna_pkg::cmd_t    cmd_head;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             out_full;
  logic             res_push;
  vna_pkg::result_t res_beat;

  // range check against the live vertex count
  vna_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd_in)
  );

  // classified commands wait here for the sequencer
  vna_fifo #(.WIDTH($bits(vna_pkg::cmd_t))) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .empty (cmd_empty)
  );

  // stores and arithmetic
  vna_back #(.MAX_VERTICES(MAX_VERTICES), .ACCUM_BITS(ACCUM_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .res_push  (res_push),
    .res       (res_beat)
  );

  // finished results wait here for the consumer
  vna_fifo #(.WIDTH($bits(vna_pkg::result_t))) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_beat),
    .full  (out_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

endmodule

`default_nettype wire

/* design/vna_fifo.sv */
// vna_fifo: two-entry queue used between front and back and on the result side
// no package dependency
`default_nettype none

module vna_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wp;
  logic             rp;
  logic [1:0]       cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

/* design/vna_front.sv */
// vna_front: vertex count register and index range check of incoming items
// depends on vna_pkg
`default_nettype none

module vna_front #(
  parameter int MAX_VERTICES = 1024
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [vna_pkg::CFG_W-1:0] cfg_data,
  input  wire vna_pkg::item_t          item,
  output vna_pkg::cmd_t                cmd
);

  logic [vna_pkg::CFG_W-1:0] vertex_count;
  logic ok_a;
  logic ok_b;
  logic ok_c;

  function automatic logic in_range(input logic [vna_pkg::IDX_W-1:0] idx,
                                    input logic [vna_pkg::CFG_W-1:0] cnt);
    in_range = (vna_pkg::CFG_W'(idx) < cnt) && (32'(idx) < 32'(MAX_VERTICES));
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_valid) begin
      vertex_count <= cfg_data;
    end
  end

  assign ok_a = in_range(item.index_a, vertex_count);
  assign ok_b = in_range(item.index_b, vertex_count);
  assign ok_c = in_range(item.index_c, vertex_count);

  always_comb begin
    cmd.item = item;
    unique case (item.op)
      vna_pkg::OP_TRI:   cmd.range_err = !(ok_a && ok_b && ok_c);
      vna_pkg::OP_CLEAR: cmd.range_err = 1'b0;
      default:           cmd.range_err = !ok_a;
    endcase
  end

endmodule

`default_nettype wire

/* design/vna_norm.sv */
// vna_norm: cross product of two triangle edges scaled to a unit normal in q1.14
// depends on vna_pkg; iterative square root and shared restoring divider
`default_nettype none

module vna_norm (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire vna_pkg::pos_t pa,
  input  wire vna_pkg::pos_t pb,
  input  wire vna_pkg::pos_t pc,
  output vna_pkg::nrm_res_t  res
);

  localparam logic [3:0] N_IDLE  = 4'd0;
  localparam logic [3:0] N_MUL   = 4'd1;
  localparam logic [3:0] N_CROSS = 4'd2;
  localparam logic [3:0] N_SHIFT = 4'd3;
  localparam logic [3:0] N_SQ    = 4'd4;
  localparam logic [3:0] N_SUM   = 4'd5;
  localparam logic [3:0] N_SQRT  = 4'd6;
  localparam logic [3:0] N_DSET  = 4'd7;
  localparam logic [3:0] N_DIV   = 4'd8;
  localparam logic [3:0] N_DONE  = 4'd9;

  logic [3:0]         state;
  logic signed [16:0] e1 [3];
  logic signed [16:0] e2 [3];
  logic signed [33:0] p [6];
  logic signed [34:0] c [3];
  logic [33:0]        mag [3];
  logic               neg [3];
  logic [30:0]        ms [3];
  logic [61:0]        sq [3];
  logic [63:0]        rad;
  logic [31:0]        sroot;
  logic [34:0]        srem;
  logic [4:0]         cnt;
  logic [31:0]        len;
  logic [31:0]        drem;
  logic [14:0]        dlow;
  logic [14:0]        quo;
  logic [1:0]         comp;
  logic signed [15:0] nv [3];
  logic               degen;

  logic [33:0] orm;
  logic [1:0]  sh;
  logic [34:0] st_rem;
  logic [34:0] trial;
  logic [45:0] num;
  logic [32:0] dt;
  logic        qbit;
  logic [14:0] qn;

  assign c[0] = 35'(p[0]) - 35'(p[1]);
  assign c[1] = 35'(p[2]) - 35'(p[3]);
  assign c[2] = 35'(p[4]) - 35'(p[5]);

  assign orm = mag[0] | mag[1] | mag[2];
  always_comb begin
    if (orm[33]) sh = 2'd3;
    else if (orm[32]) sh = 2'd2;
    else if (orm[31]) sh = 2'd1;
    else sh = 2'd0;
  end

  assign st_rem = {srem[32:0], rad[63:62]};
  assign trial  = {1'b0, sroot, 2'b01};
  assign num    = 46'({ms[comp], 14'b0}) + 46'(len >> 1);
  assign dt     = {drem, dlow[14]};
  assign qbit   = (dt >= {1'b0, len});
  assign qn     = {quo[13:0], qbit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      unique case (state)
        N_IDLE: if (start) state <= N_MUL;
        N_MUL: state <= N_CROSS;
        N_CROSS: state <= (c[0] == '0 && c[1] == '0 && c[2] == '0) ? N_DONE : N_SHIFT;
        N_SHIFT: state <= N_SQ;
        N_SQ: state <= N_SUM;
        N_SUM: state <= N_SQRT;
        N_SQRT: if (cnt == 5'd31) state <= N_DSET;
        N_DSET: state <= N_DIV;
        N_DIV: if (cnt == 5'd14) state <= (comp == 2'd2) ? N_DONE : N_DSET;
        N_DONE: state <= N_IDLE;
        default: state <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      N_IDLE: begin
        e1[0] <= 17'(pb.x) - 17'(pa.x);
        e1[1] <= 17'(pb.y) - 17'(pa.y);
        e1[2] <= 17'(pb.z) - 17'(pa.z);
        e2[0] <= 17'(pc.x) - 17'(pa.x);
        e2[1] <= 17'(pc.y) - 17'(pa.y);
        e2[2] <= 17'(pc.z) - 17'(pa.z);
        degen <= 1'b0;
      end
      N_MUL: begin
        p[0] <= e1[1] * e2[2];
        p[1] <= e1[2] * e2[1];
        p[2] <= e1[2] * e2[0];
        p[3] <= e1[0] * e2[2];
        p[4] <= e1[0] * e2[1];
        p[5] <= e1[1] * e2[0];
      end
      N_CROSS: begin
        for (int k = 0; k < 3; k++) begin
          neg[k] <= c[k][34];
          mag[k] <= c[k][34] ? 34'(-c[k]) : 34'(c[k]);
        end
        degen <= (c[0] == '0 && c[1] == '0 && c[2] == '0);
      end
      N_SHIFT: begin
        for (int k = 0; k < 3; k++) ms[k] <= 31'(mag[k] >> sh);
      end
      N_SQ: begin
        for (int k = 0; k < 3; k++) sq[k] <= 62'(ms[k]) * 62'(ms[k]);
      end
      N_SUM: begin
        rad   <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
        sroot <= '0;
        srem  <= '0;
        cnt   <= '0;
      end
      N_SQRT: begin
        rad <= {rad[61:0], 2'b00};
        cnt <= cnt + 5'd1;
        if (st_rem >= trial) begin
          srem  <= st_rem - trial;
          sroot <= {sroot[30:0], 1'b1};
        end else begin
          srem  <= st_rem;
          sroot <= {sroot[30:0], 1'b0};
        end
        if (cnt == 5'd31) begin
          comp <= 2'd0;
          len  <= (sroot[30:0] == '0 && st_rem < trial) ? 32'd1 :
                  ((st_rem >= trial) ? {sroot[30:0], 1'b1} : {sroot[30:0], 1'b0});
        end
      end
      N_DSET: begin
        drem <= 32'(num[45:15]);
        dlow <= num[14:0];
        quo  <= '0;
        cnt  <= '0;
      end
      N_DIV: begin
        drem <= qbit ? 32'(dt - {1'b0, len}) : dt[31:0];
        dlow <= {dlow[13:0], 1'b0};
        quo  <= qn;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd14) begin
          nv[comp] <= neg[comp] ? -16'(qn) : 16'(qn);
          comp     <= comp + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign res.done  = (state == N_DONE);
  assign res.degen = degen;
  assign res.nx    = nv[0];
  assign res.ny    = nv[1];
  assign res.nz    = nv[2];

endmodule

`default_nettype wire

/* design/vna_back.sv */
// vna_back: sequencer that carries out commands on the position and accumulator stores
// depends on vna_pkg and vna_norm
`default_nettype none

module vna_back #(
  parameter int MAX_VERTICES = 1024,
  parameter int ACCUM_BITS   = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire vna_pkg::cmd_t cmd,
  input  wire logic          cmd_empty,
  output logic               cmd_pop,
  input  wire logic          out_full,
  output logic               res_push,
  output vna_pkg::result_t   res
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int EW = 3 * ACCUM_BITS;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LOAD   = 4'd2;
  localparam logic [3:0] S_RDA    = 4'd3;
  localparam logic [3:0] S_RDB    = 4'd4;
  localparam logic [3:0] S_RDC    = 4'd5;
  localparam logic [3:0] S_PC     = 4'd6;
  localparam logic [3:0] S_NORM   = 4'd7;
  localparam logic [3:0] S_ACC_RD = 4'd8;
  localparam logic [3:0] S_ACC_WR = 4'd9;
  localparam logic [3:0] S_RD_ACC = 4'd10;
  localparam logic [3:0] S_RD_OUT = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0]           state;
  vna_pkg::item_t       cur;
  logic [AW-1:0]        clr_cnt;
  logic                 clr_res;
  logic [1:0]           corner;
  logic                 sat_any;
  vna_pkg::pos_t        pa;
  vna_pkg::pos_t        pb;

  vna_pkg::pos_t        pos_mem [MAX_VERTICES];
  vna_pkg::pos_t        pos_q;
  logic [AW-1:0]        pos_addr;
  logic                 pos_we;

  logic [EW-1:0]        acc_mem [MAX_VERTICES];
  logic [EW-1:0]        acc_q;
  logic [EW-1:0]        acc_wd;
  logic [AW-1:0]        acc_addr;
  logic                 acc_we;

  vna_pkg::nrm_res_t    nres;
  logic                 nrm_start;
  logic [ACCUM_BITS:0]  sx;
  logic [ACCUM_BITS:0]  sy;
  logic [ACCUM_BITS:0]  sz;
  logic                 sat_now;
  logic [vna_pkg::IDX_W-1:0] corner_idx;

  function automatic logic [ACCUM_BITS:0] sat_add(input logic signed [ACCUM_BITS-1:0] a,
                                                  input logic signed [15:0] n);
    logic signed [ACCUM_BITS:0] s;
    logic [ACCUM_BITS:0]        r;
    s = (ACCUM_BITS+1)'(a) + (ACCUM_BITS+1)'(n);
    if (s[ACCUM_BITS] != s[ACCUM_BITS-1]) begin
      r = {1'b1, s[ACCUM_BITS], {(ACCUM_BITS-1){~s[ACCUM_BITS]}}};
    end else begin
      r = {1'b0, s[ACCUM_BITS-1:0]};
    end
    sat_add = r;
  endfunction

  vna_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (nrm_start),
    .pa    (pa),
    .pb    (pb),
    .pc    (pos_q),
    .res   (nres)
  );

  assign nrm_start = (state == S_PC);
  assign cmd_pop   = (state == S_IDLE) && !cmd_empty && !out_full;
  assign res_push  = (state == S_DONE);

  always_comb begin
    case (corner)
      2'd0:    corner_idx = cur.index_a;
      2'd1:    corner_idx = cur.index_b;
      default: corner_idx = cur.index_c;
    endcase
  end

  always_comb begin
    case (state)
      S_RDB:   pos_addr = AW'(cur.index_b);
      S_RDC:   pos_addr = AW'(cur.index_c);
      default: pos_addr = AW'(cur.index_a);
    endcase
  end
  assign pos_we = (state == S_LOAD);

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_addr] <= '{x: cur.pos_x, y: cur.pos_y, z: cur.pos_z};
    end
    pos_q <= pos_mem[pos_addr];
  end

  assign sx = sat_add(acc_q[3*ACCUM_BITS-1:2*ACCUM_BITS], nres.nx);
  assign sy = sat_add(acc_q[2*ACCUM_BITS-1:ACCUM_BITS], nres.ny);
  assign sz = sat_add(acc_q[ACCUM_BITS-1:0], nres.nz);
  assign sat_now = sx[ACCUM_BITS] | sy[ACCUM_BITS] | sz[ACCUM_BITS];

  always_comb begin
    case (state)
      S_CLEAR:            acc_addr = clr_cnt;
      S_ACC_RD, S_ACC_WR: acc_addr = AW'(corner_idx);
      default:            acc_addr = AW'(cur.index_a);
    endcase
  end
  assign acc_we = (state == S_CLEAR) || (state == S_ACC_WR);
  assign acc_wd = (state == S_CLEAR) ? '0 :
                  {sx[ACCUM_BITS-1:0], sy[ACCUM_BITS-1:0], sz[ACCUM_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_addr] <= acc_wd;
    end
    acc_q <= acc_mem[acc_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      clr_res <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (clr_cnt == AW'(MAX_VERTICES - 1)) begin
            state   <= clr_res ? S_DONE : S_IDLE;
            clr_res <= 1'b0;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd_pop) begin
            if (cmd.range_err) begin
              state <= S_DONE;
            end else begin
              unique case (cmd.item.op)
                vna_pkg::OP_LOAD: state <= S_LOAD;
                vna_pkg::OP_TRI:  state <= S_RDA;
                vna_pkg::OP_READ: state <= S_RD_ACC;
                default: begin
                  state   <= S_CLEAR;
                  clr_cnt <= '0;
                  clr_res <= 1'b1;
                end
              endcase
            end
          end
        end
        S_LOAD:   state <= S_DONE;
        S_RDA:    state <= S_RDB;
        S_RDB:    state <= S_RDC;
        S_RDC:    state <= S_PC;
        S_PC:     state <= S_NORM;
        S_NORM:   if (nres.done) state <= nres.degen ? S_DONE : S_ACC_RD;
        S_ACC_RD: state <= S_ACC_WR;
        S_ACC_WR: state <= (corner == 2'd2) ? S_DONE : S_ACC_RD;
        S_RD_ACC: state <= S_RD_OUT;
        S_RD_OUT: state <= S_DONE;
        S_DONE:   state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // payload side of the sequencer
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (cmd_pop) begin
          cur <= cmd.item;
          res <= '{status: (cmd.range_err ? vna_pkg::ST_RANGE : vna_pkg::ST_OK),
                   normal_x: '0, normal_y: '0, normal_z: '0};
        end
      end
      S_RDB: pa <= pos_q;
      S_RDC: pb <= pos_q;
      S_NORM: begin
        corner  <= 2'd0;
        sat_any <= 1'b0;
        if (nres.done && nres.degen) res.status <= vna_pkg::ST_DEGEN;
      end
      S_ACC_WR: begin
        sat_any <= sat_any | sat_now;
        corner  <= corner + 2'd1;
        if (corner == 2'd2) begin
          res.status <= (sat_any | sat_now) ? vna_pkg::ST_SAT : vna_pkg::ST_OK;
        end
      end
      S_RD_OUT: begin
        res.normal_x <= vna_pkg::OUT_W'($signed(acc_q[3*ACCUM_BITS-1:2*ACCUM_BITS]));
        res.normal_y <= vna_pkg::OUT_W'($signed(acc_q[2*ACCUM_BITS-1:ACCUM_BITS]));
        res.normal_z <= vna_pkg::OUT_W'($signed(acc_q[ACCUM_BITS-1:0]));
      end
      default: ;
    endcase
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !out_full)
    else $error("result pushed into a full queue");

  a_norm_done_owned: assert property (@(posedge clk) disable iff (rst)
    nres.done |-> (state == S_NORM))
    else $error("normal unit finished outside a triangle");

  a_clear_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && clr_cnt != AW'(MAX_VERTICES - 1)) |=> (state == S_CLEAR))
    else $error("clearing sweep left early");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (state == S_IDLE && !out_full))
    else $error("command taken while busy");

endmodule

`default_nettype wire
